FILE: hw/rtl/segment_polygon_crossing_count_defines.svh
// assertion macros shared by the crossing counter checks
`ifndef SEGMENT_POLYGON_CROSSING_COUNT_DEFINES_SVH
`define SEGMENT_POLYGON_CROSSING_COUNT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SPCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spcc check failed");

// next-cycle implication, disabled in reset
`define SPCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spcc check failed");

`endif

FILE: hw/rtl/spcc_pkg.sv
// types and constants of the segment / polygon crossing counter
package spcc_pkg;

   localparam int CoordWidth = 16;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int ProdWidth  = 2 * DiffWidth;
   localparam int CountWidth = 8;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic [1:0]                   score_type;
   typedef logic [CountWidth-1:0]        count_type;

   typedef struct packed {
      coord_type edge_start_x;
      coord_type edge_start_y;
      coord_type edge_end_x;
      coord_type edge_end_y;
      logic      polygon_done;
      logic      set_done;
   } edge_beat_type;

   typedef struct packed {
      count_type crossed_polygons;
      logic      identical_edge_seen;
   } result_beat_type;

   typedef enum logic [1:0] {
      CsrSegStartX = 2'd0,
      CsrSegStartY = 2'd1,
      CsrSegEndX   = 2'd2,
      CsrSegEndY   = 2'd3
   } csr_index_type;

   localparam score_type ScoreMax = 2'd3;

endpackage

FILE: hw/rtl/segment_polygon_crossing_count.sv
// top level of the segment / polygon crossing counter
//
// usage
//   the query segment sits in four csr registers (start x/y, end x/y), written
//   through the csr_ channel while the block is idle; csr_ready is always high
//   polygon edges stream in on the req_ channel, one beat per edge, tagged
//   with polygon_done and set_done; a beat is taken when req_valid is high
//   and req_stall is low; one rsp_ beat comes out for each set_done edge,
//   carrying the crossed polygon count (saturating) and the identical-edge flag
// throughput and pipeline
//   one edge per cycle sustained while no result is held by rsp_stall; a
//   set_done beat passes the input register, the product register with the
//   four orientation product pairs, then compare, score update and the result
//   register; the eight 17x17 multipliers set the first stage
// reset: synchronous, active high, clears the csr, score, count, flag and valid registers
// stall behavior
//   a result waits in the output register while rsp_stall is high; the next
//   set_done edge then parks in the product stage, and once one more edge
//   fills the input register req_stall rises
module segment_polygon_crossing_count #(
   parameter int unsigned MAX_COUNT = 255
) (
   input  logic                      clock,
   input  logic                      reset,
   // edge beats
   input  logic                      req_valid,
   output logic                      req_stall,
   input  spcc_pkg::edge_beat_type   req_data,
   // result beats
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output spcc_pkg::result_beat_type rsp_data,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  spcc_pkg::csr_index_type   csr_index,
   input  spcc_pkg::coord_type       csr_data
);

   localparam spcc_pkg::count_type CountLimit =
      (MAX_COUNT < 255) ? spcc_pkg::CountWidth'(MAX_COUNT) : 8'd255;

   // query segment
   spcc_pkg::coord_type seg_sx_ff, seg_sy_ff, seg_ex_ff, seg_ey_ff;

   // input stage
   logic                    in_valid_ff;
   spcc_pkg::edge_beat_type in_data_ff;

   // product stage
   logic               p_valid_ff;
   spcc_pkg::prod_type p_t1_ff [4];
   spcc_pkg::prod_type p_t2_ff [4];
   logic               p_sp_ff, p_sq_ff, p_ep_ff, p_eq_ff;
   logic               p_poly_end_ff, p_set_end_ff;

   // accumulators
   spcc_pkg::score_type score_ff, score_in;
   spcc_pkg::count_type count_ff, count_in;
   logic                ident_ff, ident_in;

   // result register
   logic                      out_valid_ff;
   spcc_pkg::result_beat_type out_data_ff, out_data_in;

   // combinational products of the input stage
   spcc_pkg::prod_type t1 [4];
   spcc_pkg::prod_type t2 [4];

   // flow control
   logic out_free, p_go, p_hold, in_hold, in_move, req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign p_go      = p_valid_ff && (!p_set_end_ff || out_free);
   assign p_hold    = p_valid_ff && !p_go;
   assign in_hold   = in_valid_ff && p_hold;
   assign in_move   = in_valid_ff && !p_hold;
   assign req_stall = in_hold;
   assign req_take  = req_valid && !in_hold;

   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_sx_ff <= '0;
         seg_sy_ff <= '0;
         seg_ex_ff <= '0;
         seg_ey_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            spcc_pkg::CsrSegStartX: seg_sx_ff <= csr_data;
            spcc_pkg::CsrSegStartY: seg_sy_ff <= csr_data;
            spcc_pkg::CsrSegEndX:   seg_ex_ff <= csr_data;
            spcc_pkg::CsrSegEndY:   seg_ey_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (in_move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   // turn of P and Q about S->E
   spcc_turn u_turn_p (
      .ax(seg_sx_ff), .ay(seg_sy_ff), .bx(seg_ex_ff), .by(seg_ey_ff),
      .cx(in_data_ff.edge_start_x), .cy(in_data_ff.edge_start_y),
      .t1(t1[0]), .t2(t2[0])
   );

   spcc_turn u_turn_q (
      .ax(seg_sx_ff), .ay(seg_sy_ff), .bx(seg_ex_ff), .by(seg_ey_ff),
      .cx(in_data_ff.edge_end_x), .cy(in_data_ff.edge_end_y),
      .t1(t1[1]), .t2(t2[1])
   );

   // turn of S and E about P->Q
   spcc_turn u_turn_s (
      .ax(in_data_ff.edge_start_x), .ay(in_data_ff.edge_start_y),
      .bx(in_data_ff.edge_end_x), .by(in_data_ff.edge_end_y),
      .cx(seg_sx_ff), .cy(seg_sy_ff),
      .t1(t1[2]), .t2(t2[2])
   );

   spcc_turn u_turn_e (
      .ax(in_data_ff.edge_start_x), .ay(in_data_ff.edge_start_y),
      .bx(in_data_ff.edge_end_x), .by(in_data_ff.edge_end_y),
      .cx(seg_ex_ff), .cy(seg_ey_ff),
      .t1(t1[3]), .t2(t2[3])
   );

   // product register
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (in_move) begin
         p_valid_ff <= 1'b1;
      end else if (p_go) begin
         p_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         for (int i = 0; i < 4; i++) begin
            p_t1_ff[i] <= t1[i];
            p_t2_ff[i] <= t2[i];
         end
         // shared endpoint tests
         p_sp_ff <= (seg_sx_ff == in_data_ff.edge_start_x) &&
                    (seg_sy_ff == in_data_ff.edge_start_y);
         p_sq_ff <= (seg_sx_ff == in_data_ff.edge_end_x) &&
                    (seg_sy_ff == in_data_ff.edge_end_y);
         p_ep_ff <= (seg_ex_ff == in_data_ff.edge_start_x) &&
                    (seg_ey_ff == in_data_ff.edge_start_y);
         p_eq_ff <= (seg_ex_ff == in_data_ff.edge_end_x) &&
                    (seg_ey_ff == in_data_ff.edge_end_y);
         p_poly_end_ff <= in_data_ff.polygon_done;
         p_set_end_ff  <= in_data_ff.set_done;
      end
   end

   // sign compare, score and count update
   always_comb begin
      logic [3:0]          pos;
      logic [3:0]          neg;
      logic                identical;
      logic [2:0]          shared;
      logic [2:0]          sum;
      logic                crossing;
      spcc_pkg::score_type score_a;
      spcc_pkg::count_type count_a;
      logic                ident_a;

      for (int i = 0; i < 4; i++) begin
         pos[i] = p_t1_ff[i] > p_t2_ff[i];
         neg[i] = p_t1_ff[i] < p_t2_ff[i];
      end

      identical = p_sp_ff && p_eq_ff;
      shared    = 3'(p_sp_ff) + 3'(p_sq_ff) + 3'(p_ep_ff) + 3'(p_eq_ff);
      sum       = 3'(score_ff) + shared;
      // both product pairs of opposite or zero sign
      crossing  = !(pos[0] && pos[1]) && !(neg[0] && neg[1]) &&
                  !(pos[2] && pos[3]) && !(neg[2] && neg[3]);

      score_a = score_ff;
      ident_a = ident_ff || identical;
      if (!identical) begin
         if (shared != 3'd0) begin
            score_a = (sum > 3'(spcc_pkg::ScoreMax)) ? spcc_pkg::ScoreMax : sum[1:0];
         end else if (crossing) begin
            score_a = spcc_pkg::ScoreMax;
         end
      end

      // polygon close, also on set end
      count_a = count_ff;
      if (p_poly_end_ff || p_set_end_ff) begin
         if (score_a == spcc_pkg::ScoreMax && count_ff < CountLimit) begin
            count_a = count_ff + 1'b1;
         end
         score_a = '0;
      end

      out_data_in.crossed_polygons    = ident_a ? '0 : count_a;
      out_data_in.identical_edge_seen = ident_a;

      if (p_set_end_ff) begin
         score_in = '0;
         count_in = '0;
         ident_in = 1'b0;
      end else begin
         score_in = score_a;
         count_in = count_a;
         ident_in = ident_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff <= '0;
         count_ff <= '0;
         ident_ff <= 1'b0;
      end else if (p_go) begin
         score_ff <= score_in;
         count_ff <= count_in;
         ident_ff <= ident_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (p_go && p_set_end_ff) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (p_go && p_set_end_ff) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

FILE: hw/rtl/spcc_turn.sv
// product pair of one orientation test of point c about line a->b
module spcc_turn (
   input  spcc_pkg::coord_type ax,
   input  spcc_pkg::coord_type ay,
   input  spcc_pkg::coord_type bx,
   input  spcc_pkg::coord_type by,
   input  spcc_pkg::coord_type cx,
   input  spcc_pkg::coord_type cy,
   output spcc_pkg::prod_type  t1,
   output spcc_pkg::prod_type  t2
);

   logic signed [spcc_pkg::DiffWidth-1:0] d_ab_y;
   logic signed [spcc_pkg::DiffWidth-1:0] d_bc_x;
   logic signed [spcc_pkg::DiffWidth-1:0] d_bc_y;
   logic signed [spcc_pkg::DiffWidth-1:0] d_ab_x;

   assign d_ab_y = spcc_pkg::DiffWidth'(ay) - spcc_pkg::DiffWidth'(by);
   assign d_bc_x = spcc_pkg::DiffWidth'(bx) - spcc_pkg::DiffWidth'(cx);
   assign d_bc_y = spcc_pkg::DiffWidth'(by) - spcc_pkg::DiffWidth'(cy);
   assign d_ab_x = spcc_pkg::DiffWidth'(ax) - spcc_pkg::DiffWidth'(bx);

   // (ay-by)*(bx-cx) and (by-cy)*(ax-bx)
   assign t1 = spcc_pkg::ProdWidth'(d_ab_y) * spcc_pkg::ProdWidth'(d_bc_x);
   assign t2 = spcc_pkg::ProdWidth'(d_bc_y) * spcc_pkg::ProdWidth'(d_ab_x);

endmodule

FILE: hw/rtl/spcc_checker.sv
// port-level checks of the crossing counter and their bind
`include "segment_polygon_crossing_count_defines.svh"

module spcc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input spcc_pkg::result_beat_type rsp_data
);

   // result beat holds while stalled
   `SPCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // edge input backs up only behind a stalled result
   `SPCC_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // an identical edge forces a zero count
   `SPCC_ASSERT_IMPLY(a_ident_zero, clock, reset, rsp_valid && rsp_data.identical_edge_seen, rsp_data.crossed_polygons == '0)

   // nothing pending right after reset
   `SPCC_ASSERT_IMPLY(a_reset_idle, clock, reset, $past(reset), !rsp_valid && !req_stall)

endmodule

bind segment_polygon_crossing_count spcc_checker u_spcc_checker (.*);
